/* design/hpq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hpq_pkg
// shared types and constants of the binary min-heap priority queue
// ----------------------------------------------------------------------------
package hpq_pkg;

    localparam int DEF_DEPTH         = 64;
    localparam int DEF_KEY_WIDTH     = 32;
    localparam int DEF_PAYLOAD_WIDTH = 32;

    localparam int KIND_WIDTH   = 2;
    localparam int STATUS_WIDTH = 2;
    localparam int OCC_WIDTH    = 7;
    localparam int CAP_WIDTH    = 7;

    localparam int APB_DATA_WIDTH = 32;
    localparam int APB_ADDR_WIDTH = 2;

    localparam logic [APB_ADDR_WIDTH-1:0] REG_CAPACITY_ADDR = 2'd0;
    localparam logic [CAP_WIDTH-1:0]      CAP_RESET         = 7'd64;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_PEEK   = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DONE
    } state_t;

    // result of the shared compare unit
    typedef struct packed {
        logic pick_right;
        logic child_gt;
    } cmp_res_t;

endpackage
`default_nettype wire

/* design/hpq_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hpq_ram
// heap entry memory: one write port, two registered read ports
// ----------------------------------------------------------------------------
module hpq_ram #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [$clog2(DEPTH)-1:0]     waddr,
    input  wire logic [DATA_WIDTH-1:0]        wdata,
    input  wire logic [$clog2(DEPTH)-1:0]     raddr0,
    input  wire logic [$clog2(DEPTH)-1:0]     raddr1,
    output logic      [DATA_WIDTH-1:0]        rdata0,
    output logic      [DATA_WIDTH-1:0]        rdata1
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule
`default_nettype wire

/* design/hpq_cmp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hpq_cmp
// shared key compare unit: picks the smaller child and tests it against
// the entry being sifted
// ----------------------------------------------------------------------------
module hpq_cmp
    import hpq_pkg::*;
#(
    parameter int KEY_WIDTH = 32
) (
    input  wire logic [KEY_WIDTH-1:0] cur_key,
    input  wire logic [KEY_WIDTH-1:0] left_key,
    input  wire logic [KEY_WIDTH-1:0] right_key,
    input  wire logic                 use_right,
    output cmp_res_t                  res
);

    logic [KEY_WIDTH-1:0] child_key;

    always_comb
    begin
        // right child only when the left key is strictly greater
        res.pick_right = use_right && (left_key > right_key);
        child_key      = res.pick_right ? right_key : left_key;
        res.child_gt   = child_key > cur_key;
    end

endmodule
`default_nettype wire

/* design/hpq_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hpq_cfg
// apb register block holding the capacity limit
// ----------------------------------------------------------------------------
module hpq_cfg
    import hpq_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic      [APB_DATA_WIDTH-1:0] prdata,
    output logic                           pready,
    output logic      [CAP_WIDTH-1:0]      capacity
);

    logic [CAP_WIDTH-1:0] cap_reg;
    logic [CAP_WIDTH-1:0] cap_next;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == REG_CAPACITY_ADDR);

    always_comb
    begin
        cap_next = cap_reg;
        if (wr_en)
        begin
            cap_next = pwdata[CAP_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_CAPACITY_ADDR)
        begin
            prdata = APB_DATA_WIDTH'(cap_reg);
        end
    end

    assign capacity = cap_reg;

endmodule
`default_nettype wire

/* design/hpq_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hpq_core
// heap sequencer: insert with sift-up, remove with sift-down, peek, plus
// result and output registers
// ----------------------------------------------------------------------------
module hpq_core
    import hpq_pkg::*;
#(
    parameter int DEPTH         = 64,
    parameter int KEY_WIDTH     = 32,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [KIND_WIDTH-1:0]                 in_kind,
    input  wire logic [KEY_WIDTH-1:0]                  in_key,
    input  wire logic [PAYLOAD_WIDTH-1:0]              in_payload,
    input  wire logic [CAP_WIDTH-1:0]                  capacity,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic      [STATUS_WIDTH-1:0]               out_status,
    output logic      [KEY_WIDTH-1:0]                  out_key,
    output logic      [PAYLOAD_WIDTH-1:0]              out_payload,
    output logic      [OCC_WIDTH-1:0]                  out_occ,
    output logic                                       mem_we,
    output logic      [$clog2(DEPTH)-1:0]              mem_waddr,
    output logic      [KEY_WIDTH+PAYLOAD_WIDTH-1:0]    mem_wdata,
    output logic      [$clog2(DEPTH)-1:0]              mem_raddr0,
    output logic      [$clog2(DEPTH)-1:0]              mem_raddr1,
    input  wire logic [KEY_WIDTH+PAYLOAD_WIDTH-1:0]    mem_rdata0,
    input  wire logic [KEY_WIDTH+PAYLOAD_WIDTH-1:0]    mem_rdata1
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IW      = AW + 2;
    localparam int LIM_W   = (CNT_W > CAP_WIDTH) ? CNT_W : CAP_WIDTH;
    localparam int ENTRY_W = KEY_WIDTH + PAYLOAD_WIDTH;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic [ENTRY_W-1:0]       cur_reg, cur_next;
    kind_t                    kind_reg, kind_next;
    logic                     right_reg, right_next;
    status_t                  rstat_reg, rstat_next;
    logic [KEY_WIDTH-1:0]     rkey_reg, rkey_next;
    logic [PAYLOAD_WIDTH-1:0] rpay_reg, rpay_next;

    logic                     out_valid_reg, out_valid_next;
    logic [STATUS_WIDTH-1:0]  out_status_reg;
    logic [KEY_WIDTH-1:0]     out_key_reg;
    logic [PAYLOAD_WIDTH-1:0] out_pay_reg;
    logic [OCC_WIDTH-1:0]     out_occ_reg;
    logic                     load_out;

    logic [CNT_W-1:0]         count_m1;
    logic [AW-1:0]            last_idx;
    logic [AW-1:0]            pos_m1;
    logic [AW-1:0]            parent_idx;
    logic [IW-1:0]            left_idx;
    logic [IW-1:0]            right_idx;
    logic [IW-1:0]            count_iw;
    logic [LIM_W-1:0]         cnt_ext;
    logic [LIM_W-1:0]         cap_ext;
    logic                     full;
    kind_t                    kind_in;

    logic [KEY_WIDTH-1:0]     cmp_cur;
    logic                     cmp_use_right;
    cmp_res_t                 cmp_res;

    assign count_m1   = count_reg - CNT_W'(1);
    assign last_idx   = count_m1[AW-1:0];
    assign pos_m1     = pos_reg - AW'(1);
    assign parent_idx = pos_m1 >> 1;
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + IW'(1);
    assign count_iw   = IW'(count_reg);
    assign cnt_ext    = LIM_W'(count_reg);
    assign cap_ext    = LIM_W'(capacity);
    assign full       = (cnt_ext >= cap_ext) || (count_reg == CNT_W'(DEPTH));
    assign kind_in    = kind_t'(in_kind);
    assign cmp_cur    = cur_reg[KEY_WIDTH-1:0];

    hpq_cmp #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_cmp (
        .cur_key   (cmp_cur),
        .left_key  (mem_rdata0[KEY_WIDTH-1:0]),
        .right_key (mem_rdata1[KEY_WIDTH-1:0]),
        .use_right (cmp_use_right),
        .res       (cmp_res)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        cur_next      = cur_reg;
        kind_next     = kind_reg;
        right_next    = right_reg;
        rstat_next    = rstat_reg;
        rkey_next     = rkey_reg;
        rpay_next     = rpay_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos_reg;
        mem_wdata     = cur_reg;
        mem_raddr0    = parent_idx;
        mem_raddr1    = last_idx;
        cmp_use_right = 1'b0;
        load_out      = 1'b0;
        in_ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                mem_raddr0 = '0;
                if (in_valid)
                begin
                    rstat_next = STATUS_DONE;
                    rkey_next  = '0;
                    rpay_next  = '0;
                    kind_next  = kind_in;
                    unique case (kind_in)
                        KIND_INSERT:
                        begin
                            if (full)
                            begin
                                rstat_next = STATUS_FULL;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                cur_next   = {in_payload, in_key};
                                pos_next   = count_reg[AW-1:0];
                                count_next = count_reg + CNT_W'(1);
                                state_next = ST_UP_RD;
                            end
                        end
                        KIND_REMOVE, KIND_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                rstat_next = STATUS_EMPTY;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                // root on port 0, last entry on port 1
                                state_next = ST_ROOT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_ROOT:
            begin
                rkey_next = mem_rdata0[KEY_WIDTH-1:0];
                rpay_next = mem_rdata0[ENTRY_W-1:KEY_WIDTH];
                if (kind_reg == KIND_REMOVE)
                begin
                    cur_next   = mem_rdata1;
                    count_next = count_m1;
                    pos_next   = '0;
                    state_next = (count_m1 == '0) ? ST_DONE : ST_DN_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP:
            begin
                mem_we = 1'b1;
                // parent strictly greater: parent moves down into the hole
                if (cmp_res.child_gt)
                begin
                    mem_wdata  = mem_rdata0;
                    pos_next   = parent_idx;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DN_RD:
            begin
                mem_raddr0 = left_idx[AW-1:0];
                mem_raddr1 = right_idx[AW-1:0];
                right_next = right_idx < count_iw;
                if (left_idx >= count_iw)
                begin
                    mem_we     = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DN_CMP;
                end
            end

            ST_DN_CMP:
            begin
                mem_we        = 1'b1;
                cmp_use_right = right_reg;
                if (cmp_res.child_gt)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    // equal keys swap too
                    mem_wdata  = cmp_res.pick_right ? mem_rdata1 : mem_rdata0;
                    pos_next   = cmp_res.pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
                    state_next = ST_DN_RD;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        cur_reg   <= cur_next;
        kind_reg  <= kind_next;
        right_reg <= right_next;
        rstat_reg <= rstat_next;
        rkey_reg  <= rkey_next;
        rpay_reg  <= rpay_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= rstat_reg;
            out_key_reg    <= rkey_reg;
            out_pay_reg    <= rpay_reg;
            out_occ_reg    <= cnt_ext[OCC_WIDTH-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_pay_reg;
    assign out_occ     = out_occ_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UP_CMP |-> pos_reg != '0)
        else $error("sift-up compare at root");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> CNT_W'(mem_waddr) < count_reg)
        else $error("heap write outside held entries");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind_in == KIND_INSERT && !full)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the heap");

    a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !out_ready)
        |=> state_reg == ST_DONE && out_valid_reg)
        else $error("result lost while receiver stalls");
`endif

endmodule
`default_nettype wire

/* design/binary_min_heap_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// array-based binary min-heap priority queue with apb capacity register
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one operation per transaction: s_tuser is the kind (insert,
//   remove minimum, peek minimum), s_tdata holds key and payload.
//   m_* returns exactly one result per operation: m_tuser is the status,
//   m_tdata holds key, payload and occupancy after the operation.
//   capacity_limit sits at apb address 0; write it only while idle.
// timing:
//   an empty remove or peek, a dropped insert or a no-op goes straight to
//   the result state; a peek reads the root first. insert climbs until it
//   stops at or below the root; remove reads the root and last entry and
//   ends there if that empties the heap, else descends. each level is one
//   registered read and one pass through the shared key compare unit.
//   s_tready is high only while idle, so a new operation is accepted only
//   once the last result has been loaded into the output register.
// reset:
//   the heap empties and capacity_limit returns to 64; memory contents
//   are not cleared, only entries below the count are ever used.
// stall:
//   a result waits in the output register while m_tready is low; a second
//   finished operation then waits in the sequencer until the slot frees.
// ----------------------------------------------------------------------------
module binary_min_heap_queue
    import hpq_pkg::*;
#(
    parameter int DEPTH         = DEF_DEPTH,
    parameter int KEY_WIDTH     = DEF_KEY_WIDTH,
    parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH,
    localparam int S_W = ((KEY_WIDTH + PAYLOAD_WIDTH + 7) / 8) * 8,
    localparam int M_W = ((KEY_WIDTH + PAYLOAD_WIDTH + OCC_WIDTH + 7) / 8) * 8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [S_W-1:0]            s_tdata,   // key, payload
    input  wire logic [KIND_WIDTH-1:0]     s_tuser,   // kind
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [M_W-1:0]            m_tdata,   // out_key, out_payload, occupancy
    output logic      [STATUS_WIDTH-1:0]   m_tuser,   // status
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic      [APB_DATA_WIDTH-1:0] prdata,
    output logic                           pready
);

    localparam int AW      = $clog2(DEPTH);
    localparam int ENTRY_W = KEY_WIDTH + PAYLOAD_WIDTH;

    logic [CAP_WIDTH-1:0]     capacity;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [ENTRY_W-1:0]       mem_wdata;
    logic [AW-1:0]            mem_raddr0;
    logic [AW-1:0]            mem_raddr1;
    logic [ENTRY_W-1:0]       mem_rdata0;
    logic [ENTRY_W-1:0]       mem_rdata1;
    logic [KEY_WIDTH-1:0]     res_key;
    logic [PAYLOAD_WIDTH-1:0] res_payload;
    logic [OCC_WIDTH-1:0]     res_occ;

    hpq_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    hpq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (ENTRY_W)
    ) u_ram (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .raddr0 (mem_raddr0),
        .raddr1 (mem_raddr1),
        .rdata0 (mem_rdata0),
        .rdata1 (mem_rdata1)
    );

    hpq_core #(
        .DEPTH         (DEPTH),
        .KEY_WIDTH     (KEY_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (s_tuser),
        .in_key      (s_tdata[KEY_WIDTH-1:0]),
        .in_payload  (s_tdata[ENTRY_W-1:KEY_WIDTH]),
        .capacity    (capacity),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (m_tuser),
        .out_key     (res_key),
        .out_payload (res_payload),
        .out_occ     (res_occ),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr0  (mem_raddr0),
        .mem_raddr1  (mem_raddr1),
        .mem_rdata0  (mem_rdata0),
        .mem_rdata1  (mem_rdata1)
    );

    assign m_tdata = M_W'({res_occ, res_payload, res_key});

endmodule
`default_nettype wire
